### design/ps2kr_pkg.sv
// Shared types and constants for the PS/2 keyboard receiver with key map.
// This file has no dependencies. Every other design file uses it by scoped names.
package ps2kr_pkg;

  // These are the operation codes carried in an input beat.
  typedef enum logic [2:0] {
    OP_EDGE      = 3'd0,
    OP_TICK      = 3'd1,
    OP_CHECK     = 3'd2,
    OP_CHECK_REL = 3'd3,
    OP_CLR_OVF   = 3'd4
  } op_e;

  localparam int unsigned NumKeys       = 256;
  localparam int unsigned CodeW         = 8;
  localparam int unsigned CountW        = 4;
  localparam int unsigned IdleW         = 16;
  localparam logic [CountW-1:0] FrameBits = 4'd11;
  localparam logic [CodeW-1:0]  ReleasePrefix = 8'hF0;
  localparam logic [IdleW-1:0]  GapLimitReset = 16'd250;
  localparam logic [IdleW-1:0]  IdleMax       = 16'hFFFF;

  // This is one input beat.
  typedef struct packed {
    logic [2:0]       op;
    logic             data_bit;
    logic [CodeW-1:0] key_code;
  } in_t;

  // This is one result beat.
  typedef struct packed {
    logic             key_pressed;
    logic             frame_done;
    logic [CodeW-1:0] scan_code;
    logic             release_pending;
    logic             map_cleared;
  } out_t;

  // A completed frame is passed from the frame assembler to the key map.
  typedef struct packed {
    logic             done;
    logic [CodeW-1:0] code;
  } frame_t;

  // These are the key map's contributions to a result beat.
  typedef struct packed {
    logic pressed;
    logic release_pending;
    logic cleared;
  } map_res_t;

endpackage

### design/ps2kr_frame.sv
// Frame assembler for the PS/2 keyboard receiver: it holds the bit counter, the shift byte and the idle timer.
// It depends on ps2kr_pkg.
module ps2kr_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [2:0]                   op_i,
  input  logic                         data_bit_i,
  input  logic [ps2kr_pkg::IdleW-1:0]  gap_limit_i,
  output ps2kr_pkg::frame_t            frame_o
);

  logic [ps2kr_pkg::CountW-1:0] count_q, count_d;
  logic [ps2kr_pkg::CodeW-1:0]  shift_q, shift_d;
  logic [ps2kr_pkg::IdleW-1:0]  idle_q, idle_d;

  logic [ps2kr_pkg::CountW-1:0] count_base;
  logic [ps2kr_pkg::CountW-1:0] count_next;
  logic [ps2kr_pkg::CountW-1:0] count_less;
  logic [ps2kr_pkg::CodeW-1:0]  shift_base;
  logic [ps2kr_pkg::CodeW-1:0]  shift_new;
  logic                         in_data_bits;

  // A long idle gap drops the partial frame before the new bit is used.
  always_comb begin
    if (idle_q > gap_limit_i) begin
      count_base = '0;
      shift_base = '0;
    end else begin
      count_base = count_q;
      shift_base = shift_q;
    end
    count_less   = count_base - 4'd1;
    in_data_bits = (count_base >= 4'd1) && (count_base <= 4'd8);
    shift_new    = shift_base;
    if (in_data_bits) begin
      shift_new[count_less[2:0]] = shift_base[count_less[2:0]] | data_bit_i;
    end
    count_next = count_base + 4'd1;
  end

  // The next state and the completed frame are produced here.
  always_comb begin
    count_d      = count_q;
    shift_d      = shift_q;
    idle_d       = idle_q;
    frame_o.done = 1'b0;
    frame_o.code = '0;
    case (ps2kr_pkg::op_e'(op_i))
      ps2kr_pkg::OP_EDGE: begin
        idle_d = '0;
        if (count_next == ps2kr_pkg::FrameBits) begin
          frame_o.done = 1'b1;
          frame_o.code = shift_new;
          count_d      = '0;
          shift_d      = '0;
        end else begin
          count_d = count_next;
          shift_d = shift_new;
        end
      end
      ps2kr_pkg::OP_TICK: begin
        if (idle_q != ps2kr_pkg::IdleMax) begin
          idle_d = idle_q + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // The state advances only when a beat is executed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      shift_q <= '0;
      idle_q  <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      shift_q <= shift_d;
      idle_q  <= idle_d;
    end
  end

endmodule

### design/ps2kr_keymap.sv
// Key map for the PS/2 keyboard receiver: it holds 256 pressed flags and the release prefix flag.
// It depends on ps2kr_pkg. A flag that is set means the key is pressed, so that reset leaves every key released.
module ps2kr_keymap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [2:0]                   op_i,
  input  logic [ps2kr_pkg::CodeW-1:0]  key_code_i,
  input  ps2kr_pkg::frame_t            frame_i,
  output ps2kr_pkg::map_res_t          res_o
);

  logic [ps2kr_pkg::NumKeys-1:0] pressed_q, pressed_d;
  logic                          release_q, release_d;
  logic [ps2kr_pkg::CodeW-1:0]   rd_addr;
  logic                          rd_pressed;

  // A single read port is used. An edge reads at the completed code, and a query reads at its key.
  always_comb begin
    if (ps2kr_pkg::op_e'(op_i) == ps2kr_pkg::OP_EDGE) begin
      rd_addr = frame_i.code;
    end else begin
      rd_addr = key_code_i;
    end
    rd_pressed = pressed_q[rd_addr];
  end

  // The map is updated and the query answered here.
  always_comb begin
    pressed_d     = pressed_q;
    release_d     = release_q;
    res_o.pressed = 1'b0;
    res_o.cleared = 1'b0;
    case (ps2kr_pkg::op_e'(op_i))
      ps2kr_pkg::OP_EDGE: begin
        if (frame_i.done) begin
          if (release_q) begin
            if (rd_pressed) begin
              pressed_d[rd_addr] = 1'b0;
            end else begin
              // Releasing a key that is already released clears the whole map.
              pressed_d     = '0;
              res_o.cleared = 1'b1;
            end
          end else begin
            pressed_d[rd_addr] = 1'b1;
          end
          release_d = (frame_i.code == ps2kr_pkg::ReleasePrefix);
        end
      end
      ps2kr_pkg::OP_CHECK: begin
        res_o.pressed = rd_pressed;
      end
      ps2kr_pkg::OP_CHECK_REL: begin
        res_o.pressed      = rd_pressed;
        pressed_d[rd_addr] = 1'b0;
      end
      ps2kr_pkg::OP_CLR_OVF: begin
        pressed_d[0] = 1'b0;
      end
      default: begin
      end
    endcase
    res_o.release_pending = release_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      release_q <= 1'b0;
    end else if (step_i) begin
      pressed_q <= pressed_d;
      release_q <= release_d;
    end
  end

endmodule

### design/ps2_keyboard_receiver_keymap.sv
// Top level of the PS/2 keyboard receiver with key map.
// It holds the input stage, the result register and the gap limit.
// It depends on ps2kr_pkg, ps2kr_frame and ps2kr_keymap.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    in_data_i  (ps2kr_pkg::in_t)
//   result    out_valid_o / out_ready_i  out_data_o (ps2kr_pkg::out_t)
//   config    cfg_we_i                   cfg_wdata_i (gap_limit_ms)
//
// Every beat gives exactly one result: the beat is held in the input register until the result
// register is free or is being emptied, and the frame and key map logic then computes its result
// into the result register. A new beat is taken every cycle while results are being drained.
// When the result register is held, the input register still takes one more beat.
// Reset releases every key, clears the frame and idle state and sets the gap limit to 250.
module ps2_keyboard_receiver_keymap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ps2kr_pkg::in_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ps2kr_pkg::out_t             out_data_o,
  input  logic                        cfg_we_i,
  input  logic [ps2kr_pkg::IdleW-1:0] cfg_wdata_i
);

  logic                        in_valid_q, in_valid_d;
  ps2kr_pkg::in_t              in_data_q;
  logic                        out_valid_q, out_valid_d;
  ps2kr_pkg::out_t             out_data_q, out_data_d;
  logic [ps2kr_pkg::IdleW-1:0] gap_limit_q;
  logic                        exec;
  logic                        in_fire;
  ps2kr_pkg::frame_t           frame;
  ps2kr_pkg::map_res_t         map_res;

  // A beat executes when the result register is free or is being emptied.
  assign exec       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_fire || (in_valid_q && !exec);
  assign out_valid_d = exec || (out_valid_q && !out_ready_i);

  // This is the gap limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= ps2kr_pkg::GapLimitReset;
    end else if (cfg_we_i) begin
      gap_limit_q <= cfg_wdata_i;
    end
  end

  // This is the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
  end

  ps2kr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (exec),
    .op_i        (in_data_q.op),
    .data_bit_i  (in_data_q.data_bit),
    .gap_limit_i (gap_limit_q),
    .frame_o     (frame)
  );

  ps2kr_keymap u_keymap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (exec),
    .op_i       (in_data_q.op),
    .key_code_i (in_data_q.key_code),
    .frame_i    (frame),
    .res_o      (map_res)
  );

  // The result beat is assembled here.
  always_comb begin
    out_data_d.key_pressed     = map_res.pressed;
    out_data_d.frame_done      = frame.done;
    out_data_d.scan_code       = frame.code;
    out_data_d.release_pending = map_res.release_pending;
    out_data_d.map_cleared     = map_res.cleared;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The map can only be cleared by a completed frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.map_cleared |-> out_data_o.frame_done)
    else $error("map cleared without a completed frame");

  // The release flag follows the code of the frame that has just completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |->
      (out_data_o.release_pending ==
       (out_data_o.scan_code == ps2kr_pkg::ReleasePrefix)))
    else $error("release flag does not match completed code");

  // Back pressure reaches the input only when both registers are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while a stage is free");

endmodule

### dv/ps2_keyboard_receiver_keymap_test.sv
// Self-checking testbench for the PS/2 keyboard receiver with its 256-key map.
// It drives frames, ticks and key queries through the valid/ready channels and checks every
// result beat against its own model of the block. It depends on ps2kr_pkg and the top level.
`timescale 1ns / 1ps

module ps2_keyboard_receiver_keymap_test;

  localparam int unsigned StuckLimit    = 2000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned ShortGapMax   = 300;
  localparam int unsigned LongTicks     = 64;

  // Op encodings that the block does not decode.
  localparam logic [2:0] OpUnusedFirst = 3'd5;
  localparam logic [2:0] OpUnusedLast  = 3'd7;

  localparam logic [ps2kr_pkg::IdleW-1:0] GapSettings [5] =
    '{16'd0, 16'd1, 16'd3, ps2kr_pkg::IdleMax, 16'd2};
  localparam logic [ps2kr_pkg::IdleW-1:0] GapFinal = 16'd12;

  // A handful of keys that come back often, so that presses and releases meet.
  localparam logic [ps2kr_pkg::CodeW-1:0] KeyPool [8] = '{8'h00, 8'h1C, 8'h12, 8'hE0,
                                                          8'hFF, 8'h5A, 8'h76, 8'hF0};

  // Model of the frame assembler and key map, with the queue of results still to come.
  class keymap_scoreboard;
    logic [ps2kr_pkg::NumKeys-1:0] key_released;
    logic [ps2kr_pkg::CountW-1:0]  bit_count;
    logic [ps2kr_pkg::CodeW-1:0]   shift_byte;
    logic                          release_flag;
    logic [ps2kr_pkg::IdleW-1:0]   idle_ms;
    logic [ps2kr_pkg::IdleW-1:0]   gap_limit;
    ps2kr_pkg::out_t               expected_q[$];
    int unsigned                   mismatches;

    function new();
      key_released = '1;
      bit_count    = '0;
      shift_byte   = '0;
      release_flag = 1'b0;
      idle_ms      = '0;
      gap_limit    = ps2kr_pkg::GapLimitReset;
      mismatches   = 0;
    endfunction

    // Works out the result of one accepted input beat and queues it.
    function void note_beat(ps2kr_pkg::in_t beat);
      ps2kr_pkg::out_t             res;
      logic [ps2kr_pkg::CodeW-1:0] code;
      res = '0;
      case (beat.op)
        ps2kr_pkg::OP_EDGE: begin
          // A long idle gap throws away whatever part of a frame has arrived.
          if (idle_ms > gap_limit) begin
            bit_count  = '0;
            shift_byte = '0;
          end
          idle_ms = '0;
          // Only the eight code bits land in the shift byte, least significant first.
          if (bit_count >= 1 && bit_count <= 8) begin
            shift_byte = shift_byte | (ps2kr_pkg::CodeW'(beat.data_bit) << (bit_count - 1));
          end
          bit_count = bit_count + 1'b1;
          if (bit_count == ps2kr_pkg::FrameBits) begin
            code          = shift_byte;
            res.frame_done = 1'b1;
            res.scan_code  = code;
            if (release_flag) begin
              if (!key_released[code]) begin
                key_released[code] = 1'b1;
              end else begin
                key_released  = '1;
                res.map_cleared = 1'b1;
              end
            end else begin
              key_released[code] = 1'b0;
            end
            release_flag = (code == ps2kr_pkg::ReleasePrefix);
            bit_count    = '0;
            shift_byte   = '0;
          end
        end
        ps2kr_pkg::OP_TICK: begin
          if (idle_ms != ps2kr_pkg::IdleMax) idle_ms = idle_ms + 1'b1;
        end
        ps2kr_pkg::OP_CHECK: begin
          res.key_pressed = !key_released[beat.key_code];
        end
        ps2kr_pkg::OP_CHECK_REL: begin
          res.key_pressed = !key_released[beat.key_code];
          key_released[beat.key_code] = 1'b1;
        end
        ps2kr_pkg::OP_CLR_OVF: begin
          key_released[0] = 1'b1;
        end
        default: begin
        end
      endcase
      res.release_pending = release_flag;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Compares one accepted result beat with the oldest outstanding prediction.
    task check_result(ps2kr_pkg::out_t got);
      ps2kr_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.key_pressed !== want.key_pressed)
        report_mismatch($sformatf("key_pressed %b, expected %b", got.key_pressed,
                                  want.key_pressed));
      if (got.frame_done !== want.frame_done)
        report_mismatch($sformatf("frame_done %b, expected %b", got.frame_done,
                                  want.frame_done));
      if (got.scan_code !== want.scan_code)
        report_mismatch($sformatf("scan_code %h, expected %h", got.scan_code, want.scan_code));
      if (got.release_pending !== want.release_pending)
        report_mismatch($sformatf("release_pending %b, expected %b", got.release_pending,
                                  want.release_pending));
      if (got.map_cleared !== want.map_cleared)
        report_mismatch($sformatf("map_cleared %b, expected %b", got.map_cleared,
                                  want.map_cleared));
    endtask
  endclass

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready_o;
  ps2kr_pkg::in_t              in_data   = '0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  ps2kr_pkg::out_t             out_data;
  logic                        cfg_we    = 1'b0;
  logic [ps2kr_pkg::IdleW-1:0] cfg_wdata = '0;

  bit               send_gaps   = 1'b0;
  bit               recv_stalls = 1'b0;
  bit               hold_req    = 1'b0;
  int unsigned      beats_sent  = 0;
  int unsigned      stuck_cycles = 0;

  keymap_scoreboard board = new();

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ps2_keyboard_receiver_keymap i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Both channels are observed at the clock edge that moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) board.note_beat(in_data);
      if (out_valid_o && out_ready) board.check_result(out_data);
    end
  end

  // The run is abandoned if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("ps2_keyboard_receiver_keymap_test: errors");
      $finish;
    end
  end

  // Result side: ready with random stalls, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Builds a beat of the given op with random content in the fields it does not use.
  function automatic ps2kr_pkg::in_t make_beat(logic [2:0] op);
    ps2kr_pkg::in_t beat;
    beat.op       = op;
    beat.data_bit = 1'($urandom);
    beat.key_code = 8'($urandom);
    return beat;
  endfunction

  // Wraps a code in start, parity and stop bits of random level.
  function automatic logic [10:0] frame_of(logic [ps2kr_pkg::CodeW-1:0] code);
    return {1'($urandom), 1'($urandom), code, 1'($urandom)};
  endfunction

  function automatic logic [ps2kr_pkg::CodeW-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return ps2kr_pkg::ReleasePrefix;
    if (r < 8) return KeyPool[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic logic [ps2kr_pkg::CodeW-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return KeyPool[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // Offers one beat and returns at the edge where it is taken.
  task automatic send_beat(ps2kr_pkg::in_t beat);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic send_query(logic [2:0] op, logic [ps2kr_pkg::CodeW-1:0] key);
    ps2kr_pkg::in_t beat;
    beat          = make_beat(op);
    beat.key_code = key;
    send_beat(beat);
  endtask

  // Sends clock edges carrying frame bits first to last.
  task automatic send_edges(logic [10:0] frame, int unsigned first, int unsigned last);
    ps2kr_pkg::in_t beat;
    for (int unsigned i = first; i <= last; i++) begin
      beat          = make_beat(ps2kr_pkg::OP_EDGE);
      beat.data_bit = frame[i];
      send_beat(beat);
    end
  endtask

  task automatic send_ticks(int unsigned count);
    repeat (count) send_beat(make_beat(ps2kr_pkg::OP_TICK));
  endtask

  // Lets the block drain, then writes the gap limit while nothing is in flight.
  task automatic set_gap_limit(logic [ps2kr_pkg::IdleW-1:0] limit);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
    repeat (3) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    board.gap_limit = limit;
  endtask

  // Random traffic: mostly whole frames, with ticks, queries, broken frames and noise.
  task automatic run_phase(int unsigned budget);
    int unsigned                 target;
    int unsigned                 r;
    logic [ps2kr_pkg::CodeW-1:0] code;
    logic [10:0]                 frm;
    target = beats_sent + budget;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        code = pick_code();
        frm  = frame_of(code);
        if ($urandom_range(0, 9) == 0) begin
          // A frame cut short, usually followed by a gap long enough to drop it.
          send_edges(frm, 0, $urandom_range(0, 9));
          if (board.gap_limit < ShortGapMax) send_ticks(board.gap_limit + 1);
        end else if ($urandom_range(0, 4) == 0) begin
          // Ticks and queries slipped in between the bits of a frame.
          for (int unsigned i = 0; i <= 10; i++) begin
            if ($urandom_range(0, 3) == 0) send_beat(make_beat(ps2kr_pkg::OP_TICK));
            if ($urandom_range(0, 5) == 0) send_query(ps2kr_pkg::OP_CHECK, pick_key());
            send_edges(frm, i, i);
          end
        end else begin
          send_edges(frm, 0, 10);
        end
      end else if (r < 70) begin
        if ($urandom_range(0, 9) == 0 && board.gap_limit < ShortGapMax) begin
          send_ticks(board.gap_limit + 1);
        end else begin
          send_ticks($urandom_range(1, 3));
        end
      end else if (r < 90) begin
        send_query($urandom_range(0, 1) ? ps2kr_pkg::OP_CHECK : ps2kr_pkg::OP_CHECK_REL,
                   pick_key());
      end else if (r < 95) begin
        send_beat(make_beat(ps2kr_pkg::OP_CLR_OVF));
      end else begin
        send_beat(make_beat(3'($urandom_range(OpUnusedFirst, OpUnusedLast))));
      end
    end
  endtask

  initial begin
    logic [10:0] frm;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, undecoded ops, and a frame whose framing bits are all high.
    send_query(ps2kr_pkg::OP_CHECK, 8'h00);
    send_query(ps2kr_pkg::OP_CHECK_REL, 8'hFF);
    for (int o = OpUnusedFirst; o <= OpUnusedLast; o++) send_beat(make_beat(3'(o)));
    send_beat(make_beat(ps2kr_pkg::OP_CLR_OVF));
    send_edges({1'b1, 1'b1, 8'h00, 1'b1}, 0, 10);
    send_query(ps2kr_pkg::OP_CHECK, 8'h00);
    send_beat(make_beat(ps2kr_pkg::OP_CLR_OVF));
    send_query(ps2kr_pkg::OP_CHECK, 8'h00);
    send_query(ps2kr_pkg::OP_CHECK_REL, 8'h00);

    // Random traffic under several gap limits, starting with a long result hold-off.
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    hold_req    = 1'b1;
    run_phase(ItemsPerPhase);
    foreach (GapSettings[i]) begin
      set_gap_limit(GapSettings[i]);
      run_phase(ItemsPerPhase);
    end

    // Wide limits: the top limit keeps a partial frame through a long idle run, and a limit
    // just under that run drops it.
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    set_gap_limit(ps2kr_pkg::IdleMax);
    frm = frame_of(8'hA5);
    send_edges(frm, 0, 2);
    send_ticks(LongTicks);
    send_edges(frm, 3, 10);
    set_gap_limit(16'(LongTicks - 1));
    frm = frame_of(8'h3C);
    send_edges(frm, 0, 2);
    send_ticks(LongTicks);
    send_edges(frm, 0, 10);

    // Final stretch at full rate on both sides.
    set_gap_limit(GapFinal);
    run_phase(ItemsPerPhase);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("ps2_keyboard_receiver_keymap_test: clean");
    end else begin
      $display("ps2_keyboard_receiver_keymap_test: errors");
    end
    $finish;
  end

endmodule
